>>> hdl/assert_macros.svh
// Assertion macros shared by the SHA-1 stream hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define SBH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define SBH_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define SBH_ASSERT(lbl, clk, rstn, prop, msg)
`define SBH_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

>>> hdl/sbh_pkg.sv
// Shared types and constants of the SHA-1 byte stream hasher.
package sbh_pkg;

  localparam int unsigned NumBlockWords = 16;
  localparam int unsigned NumRounds     = 80;
  localparam int unsigned NumDigest     = 5;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [31:0] H_INIT [NumDigest] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  // Block memory port request from the sequencer.
  typedef struct packed {
    logic        we;
    logic [3:0]  waddr;
    logic [31:0] wdata;
    logic [3:0]  raddr;
  } mem_req_t;

  // Datapath controls from the sequencer.
  typedef struct packed {
    logic       load;
    logic       round;
    logic       add;
    logic       init;
    logic [6:0] rnd;
    logic [2:0] sel;
  } core_ctl_t;

endpackage

>>> hdl/sbh_block_mem.sv
// Sixteen-word block buffer with one write port and one registered read port.
module sbh_block_mem
  import sbh_pkg::*;
(
  input  logic        clk_i,
  input  mem_req_t    mem_req_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem_q [NumBlockWords];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    rdata_q <= mem_q[mem_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sbh_core.sv
// SHA-1 round datapath: working variables, message schedule and chaining words.
module sbh_core
  import sbh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  core_ctl_t   ctl_i,
  input  logic [31:0] rdata_i,
  output logic [31:0] digest_word_o
);

  logic [31:0] chain_q [NumDigest];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] ws_q [NumBlockWords];
  logic [31:0] w_cur, w_mix, f_val, k_val, t_val;

  always_comb begin
    w_mix = ws_q[13] ^ ws_q[8] ^ ws_q[2] ^ ws_q[0];
    if (ctl_i.rnd[6:4] == 3'd0) begin
      w_cur = rdata_i;
    end else begin
      w_cur = {w_mix[30:0], w_mix[31]};
    end
    priority if (ctl_i.rnd < 7'd20) begin
      f_val = d_q ^ (b_q & (c_q ^ d_q));
      k_val = K_R0;
    end else if (ctl_i.rnd < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K_R1;
    end else if (ctl_i.rnd < 7'd60) begin
      f_val = (b_q & c_q) | (d_q & (b_q | c_q));
      k_val = K_R2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K_R3;
    end
    t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_cur;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (ctl_i.round) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      for (int i = 0; i < NumBlockWords - 1; i++) begin
        ws_q[i] <= ws_q[i+1];
      end
      ws_q[NumBlockWords-1] <= w_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDigest; i++) chain_q[i] <= H_INIT[i];
    end else if (ctl_i.init) begin
      for (int i = 0; i < NumDigest; i++) chain_q[i] <= H_INIT[i];
    end else if (ctl_i.add) begin
      chain_q[0] <= chain_q[0] + a_q;
      chain_q[1] <= chain_q[1] + b_q;
      chain_q[2] <= chain_q[2] + c_q;
      chain_q[3] <= chain_q[3] + d_q;
      chain_q[4] <= chain_q[4] + e_q;
    end
  end

  assign digest_word_o = chain_q[ctl_i.sel];

endmodule

>>> hdl/sbh_ctrl.sv
// Sequencer: byte packing, padding, round counting and digest output.
module sbh_ctrl
  import sbh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_req_t   in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mem_req_t  mem_req_o,
  output core_ctl_t ctl_o
);

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic [23:0] acc_q, acc_d;
  logic [4:0]  wptr_q, wptr_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        fin_q, fin_d;
  logic        two_q, two_d;
  logic        last_q, last_d;
  logic [31:0] pad_word;
  logic [4:0]  pad_limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      bitlen_q <= '0;
      wptr_q   <= '0;
      rnd_q    <= '0;
      idx_q    <= '0;
      fin_q    <= 1'b0;
      two_q    <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      bitlen_q <= bitlen_d;
      wptr_q   <= wptr_d;
      rnd_q    <= rnd_d;
      idx_q    <= idx_d;
      fin_q    <= fin_d;
      two_q    <= two_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Pending bytes of the partial word followed by the 0x80 marker.
  always_comb begin
    unique case (fill_q[1:0])
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {acc_q[7:0], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {acc_q[15:0], PAD_BYTE, 8'h0};
      default: pad_word = {acc_q[23:0], PAD_BYTE};
    endcase
    pad_limit = two_q ? 5'd16 : 5'd14;
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    bitlen_d  = bitlen_q;
    acc_d     = acc_q;
    wptr_d    = wptr_q;
    rnd_d     = rnd_q;
    idx_d     = idx_q;
    fin_d     = fin_q;
    two_d     = two_q;
    last_d    = last_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = wptr_q[3:0];
    mem_req_o.wdata = '0;
    mem_req_o.raddr = rnd_q[3:0] + 4'd1;
    ctl_o.load  = 1'b0;
    ctl_o.round = 1'b0;
    ctl_o.add   = 1'b0;
    ctl_o.init  = 1'b0;
    ctl_o.rnd   = rnd_q;
    ctl_o.sel   = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_req_i.cmd == CMD_ABSORB) begin
            acc_d    = {acc_q[15:0], in_req_i.data_byte};
            fill_d   = fill_q + 6'd1;
            bitlen_d = bitlen_q + 64'd8;
            if (fill_q[1:0] == 2'd3) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = fill_q[5:2];
              mem_req_o.wdata = {acc_q, in_req_i.data_byte};
            end
            if (fill_q == 6'd63) begin
              state_d = ST_LOAD;
            end
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = fill_q[5:2];
            mem_req_o.wdata = pad_word;
            wptr_d  = {1'b0, fill_q[5:2]} + 5'd1;
            fin_d   = 1'b1;
            two_d   = (fill_q >= 6'd56);
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (wptr_q < pad_limit) begin
          mem_req_o.we = 1'b1;
          wptr_d = wptr_q + 5'd1;
        end else if (two_q) begin
          state_d = ST_LOAD;
        end else begin
          state_d = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = 4'd14;
        mem_req_o.wdata = bitlen_q[63:32];
        state_d = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = 4'd15;
        mem_req_o.wdata = bitlen_q[31:0];
        last_d  = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        ctl_o.load      = 1'b1;
        mem_req_o.raddr = 4'd0;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        ctl_o.round = 1'b1;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(NumRounds - 1)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        ctl_o.add = 1'b1;
        priority if (last_q) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else if (fin_q) begin
          two_d   = 1'b0;
          wptr_d  = '0;
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'(NumDigest - 1)) begin
            ctl_o.init = 1'b1;
            idx_d    = '0;
            fill_d   = '0;
            bitlen_d = '0;
            fin_d    = 1'b0;
            two_d    = 1'b0;
            last_d   = 1'b0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/sha1_byte_stream_hasher_top.sv
// Top level of the SHA-1 byte stream hasher.
//
// Usage: each input request carries a command and a byte. An absorb request
// (cmd 0) appends data_byte to the message; a finish request (cmd 1) pads
// the message, compresses the last block(s) and returns five output requests,
// digest words h0 to h4 in order, the fifth flagged by last_word.
// Both channels use valid/ready; a request moves when both are high.
// Absorbs are taken back to back while the sequencer is idle. The 64th
// byte of a block starts the compression, which holds the input through
// one load step, 80 rounds of the shared round unit and one chaining add;
// the schedule words come from a 16-word block memory with a registered read.
// A finish makes padding writes into the block memory, two length writes
// and one compression, plus a second compression when 56 or more bytes
// were pending, then presents the digest words, one per accepted output
// cycle. Only one request is in flight at a time: the input is not ready
// while the digest is offered, so a stalled receiver holds the block until
// all five words are taken. After the last word the chaining words, byte
// count and bit length return to their initial values.
// Reset clears the sequencer and restores the SHA-1 initial chaining words;
// the block memory is not cleared, since every word is written before use.
`include "assert_macros.svh"

module sha1_byte_stream_hasher_top
  import sbh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  mem_req_t    mem_req;
  core_ctl_t   ctl;
  logic [31:0] rdata;
  logic [31:0] digest_word;

  sbh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .mem_req_o   (mem_req),
    .ctl_o       (ctl)
  );

  sbh_block_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  sbh_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .rdata_i       (rdata),
    .digest_word_o (digest_word)
  );

  // The digest word index is the sequencer's output counter.
  assign out_req_o.digest_word = digest_word;
  assign out_req_o.word_index  = ctl.sel;
  assign out_req_o.last_word   = (ctl.sel == 3'(NumDigest - 1));

  // The block is never offering a digest while it takes new input.
  `SBH_ASSERT_NEVER(a_ready_excl, clk_i, rst_ni, in_ready_o && out_valid_o,
                    "input ready while digest is offered")
  // The schedule held in the block memory must not be overwritten mid-compression.
  `SBH_ASSERT_NEVER(a_no_write_in_rounds, clk_i, rst_ni, mem_req.we && ctl.round,
                    "block memory written during rounds")
  // Digest words follow one another with increasing index.
  `SBH_ASSERT(a_word_order, clk_i, rst_ni,
              out_valid_o && out_ready_i && !out_req_o.last_word |=>
              out_valid_o && (out_req_o.word_index == $past(out_req_o.word_index) + 3'd1),
              "digest word order broken")
  // After the last word the block returns to accepting input.
  `SBH_ASSERT(a_back_to_idle, clk_i, rst_ni,
              out_valid_o && out_ready_i && out_req_o.last_word |=> in_ready_o && !out_valid_o,
              "block did not return to idle after digest")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the SHA-1 byte stream hasher top level.
`timescale 1ns / 100ps

module tb_top;
  import sbh_pkg::*;

  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned ResetCycles = 10;
  // The receiver refuses the first digest during its hold-off, so the next
  // finish request waits in front of a block that cannot move.
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned TailCycles  = 250;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MinRequests = 360;
  localparam int unsigned IdlePercent = 28;

  // The tracker models the hash engine one request at a time and keeps the
  // digest words that the block still owes. Its constants are written out
  // here rather than taken from the design package.
  class sha1_digest_tracker;
    localparam logic [31:0] RoundK [4] = '{
      32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };
    localparam logic [31:0] ChainInit [5] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    logic [31:0] chain_h [5];
    logic [7:0]  block_buf [64];
    logic [5:0]  fill;
    logic [63:0] msg_bits;
    out_req_t    expected_words [$];
    int          requests_seen;
    int          digests_owed;
    int          words_checked;
    int          errors;

    function new();
      foreach (block_buf[i]) block_buf[i] = 8'h00;
      restart();
      requests_seen = 0;
      digests_owed  = 0;
      words_checked = 0;
      errors        = 0;
    endfunction

    function void restart();
      foreach (chain_h[i]) chain_h[i] = ChainInit[i];
      fill     = '0;
      msg_bits = '0;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    // One 80-round compression of block_buf into the chaining words.
    function void compress();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++) begin
        w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
      end
      for (int r = 16; r < 80; r++) begin
        w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
      for (int r = 0; r < 80; r++) begin
        if (r < 20) begin
          f = d ^ (b & (c ^ d));
        end else if (r < 40) begin
          f = b ^ c ^ d;
        end else if (r < 60) begin
          f = (b & c) | (d & (b | c));
        end else begin
          f = b ^ c ^ d;
        end
        k = RoundK[r / 20];
        t = rotl(a, 5) + f + e + k + w[r];
        e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c;
      chain_h[3] += d; chain_h[4] += e;
    endfunction

    function void note_request(in_req_t req);
      logic [5:0] pos;
      out_req_t   word;
      pos = fill;
      requests_seen++;
      if (req.cmd == CMD_ABSORB) begin
        block_buf[pos] = req.data_byte;
        msg_bits += 64'd8;
        if (pos == 6'd63) compress();
        fill = pos + 6'd1;
      end else begin
        block_buf[pos] = 8'h80;
        for (int i = pos + 1; i < 64; i++) block_buf[i] = 8'h00;
        // No room for the length: flush this block and pad a fresh one.
        if (pos >= 6'd56) begin
          compress();
          for (int i = 0; i < 56; i++) block_buf[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) block_buf[56+i] = msg_bits[63-8*i -: 8];
        compress();
        for (int i = 0; i < 5; i++) begin
          word.digest_word = chain_h[i];
          word.word_index  = 3'(i);
          word.last_word   = (i == 4);
          expected_words.push_back(word);
        end
        digests_owed++;
        restart();
      end
    endfunction

    function void check_word(out_req_t got);
      out_req_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected digest word %h index %0d", got.digest_word, got.word_index);
        errors++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (got.digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, actual %h", want.digest_word, got.digest_word);
          errors++;
        end
        if (got.word_index !== want.word_index) begin
          $error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
          errors++;
        end
        if (got.last_word !== want.last_word) begin
          $error("last_word: expected %0b, actual %0b", want.last_word, got.last_word);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_req;

  // While calm is set neither side inserts idle cycles.
  bit       calm      = 1'b0;
  int       cycle_count = 0;
  int       msg_count   = 0;

  sha1_digest_tracker tracker = new();

  sha1_byte_stream_hasher_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req)
  );

  always #(ClkHalf) clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Offers one request and returns at the edge where it is taken. Valid is
  // only lowered for an idle gap before the next request, never in the step
  // where the next request is raised, so it does not glitch between requests.
  task automatic send_request(logic cmd, logic [7:0] data);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{cmd: cmd, data_byte: data};
    do @(posedge clk); while (!in_ready);
    tracker.note_request('{cmd: cmd, data_byte: data});
  endtask

  // Random byte, with the all-zero and all-one values drawn more often.
  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(15);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // A well-formed message: the given number of bytes and then a finish. The
  // byte of the finish request is random, since the block must ignore it.
  task automatic send_message(int n_bytes);
    for (int i = 0; i < n_bytes; i++) send_request(CMD_ABSORB, pick_byte());
    send_request(CMD_FINISH, 8'($urandom));
    msg_count++;
  endtask

  // Message lengths cluster around the padding boundaries: 55 bytes still
  // fit the length in the last block, 56 and more force an extra block, and
  // 64 fills a block exactly so the finish starts on an empty one.
  function automatic int pick_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return $urandom_range(8);
    if (sel < 65) return $urandom_range(68, 52);
    if (sel < 80) return $urandom_range(132, 116);
    return $urandom_range(200);
  endfunction

  // Receiver: a long hold-off first, then random stalls outside the calm
  // stretch. Every word taken is checked against the oldest expectation.
  initial begin
    wait (rst_n === 1'b1);
    repeat (HoldCycles) @(posedge clk);
    forever begin
      out_ready <= calm || ($urandom_range(99) >= IdlePercent);
      @(posedge clk);
      if (out_valid && out_ready) tracker.check_word(out_req);
    end
  end

  initial begin
    int noise_len;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Two empty messages back to back show the state is
    // restored after a finish; both land while the receiver is holding off,
    // so the second one stalls at the input.
    send_message(0);
    send_message(0);
    // Byte extremes in one message.
    send_request(CMD_ABSORB, 8'h00);
    send_request(CMD_ABSORB, 8'hFF);
    send_request(CMD_FINISH, 8'hFF);
    msg_count++;
    // The classic three-byte message.
    send_request(CMD_ABSORB, 8'h61);
    send_request(CMD_ABSORB, 8'h62);
    send_request(CMD_ABSORB, 8'h63);
    send_request(CMD_FINISH, 8'h00);
    msg_count++;

    // Random part: mostly well-formed messages, some noise with finish
    // requests scattered at random. A run of messages goes without gaps.
    for (int m = 0; tracker.requests_seen < MinRequests; m++) begin
      calm = (m >= 3 && m < 6);
      if ($urandom_range(9) == 0) begin
        noise_len = $urandom_range(40, 1);
        for (int i = 0; i < noise_len; i++) begin
          send_request(($urandom_range(7) == 0) ? CMD_FINISH : CMD_ABSORB, 8'($urandom));
        end
      end else begin
        send_message(pick_length());
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain: absorbs may still be compressing after the last digest word.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d requests over %0d messages (%0d digests), %0d words checked.",
             tracker.requests_seen, msg_count, tracker.digests_owed, tracker.words_checked);
    $display("Lengths spanned empty, 55/56 and full-block padding; receiver held off %0d cycles.",
             HoldCycles);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/sbh_pkg.sv
hdl/sbh_block_mem.sv
hdl/sbh_core.sv
hdl/sbh_ctrl.sv
hdl/sha1_byte_stream_hasher_top.sv
sim/tb_top.sv
